// File: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define PRCE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("prce: implication check failed");

// next-cycle implication, quiet while reset is held
`define PRCE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("prce: next-cycle check failed");

// next-cycle implication that also runs through reset
`define PRCE_ASSERT_RESET(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("prce: reset check failed");

`endif

// File: rtl/prce_pkg.sv
`timescale 1ns / 1ps

package prce_pkg;

  localparam int MAX_COLUMNS_DEF  = 8192;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int MAX_CHANNELS_DEF = 8;

  // configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int SPP_W     = 24;
  localparam int HH_W      = 12;
  localparam int COLS_W    = 14;

  localparam int OUT_W    = 13;
  localparam int CNT_W    = 17;
  localparam int BND_W    = 40;
  localparam int SPP_FRAC = 8;
  localparam int HH_MAX   = 4095;

  localparam logic [SPP_W-1:0]  SPP_MIN    = 24'd2049;
  localparam logic [SPP_W-1:0]  SPP_RESET  = 24'd16384;
  localparam logic [HH_W-1:0]   HH_RESET   = 12'd100;
  localparam logic [COLS_W-1:0] COLS_RESET = 14'd1024;

  // quotient of the mean-square divide, also the radicand of the root
  localparam int Q_W    = 2 * HH_W;
  localparam int STEP_W = $clog2(Q_W);
  localparam int HSEL_W = $clog2(HH_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPP  = 2'd0,
    CFG_HH   = 2'd1,
    CFG_SEL  = 2'd2,
    CFG_COLS = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_UPD,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              idle;
    logic              sqr;
    logic              upd;
    logic              mul1;
    logic              mul2;
    logic              div;
    logic              root;
    logic              done;
    logic              last;
    logic [STEP_W-1:0] step;
  } ctrl_t;

  typedef struct packed {
    logic fire;
    logic go;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/prce_alu.sv
`timescale 1ns / 1ps

module prce_alu #(
  parameter int W = 72
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         ge
);

  logic [W-1:0] b_x;

  assign b_x = sub ? ~b : b;
  // carry out of a - b is set when a >= b
  assign {ge, res} = {1'b0, a} + {1'b0, b_x} + (W + 1)'(sub);

endmodule

// File: rtl/prce_ctrl.sv
`timescale 1ns / 1ps

module prce_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  prce_pkg::stat_t stat,
  output prce_pkg::ctrl_t ctl
);

  import prce_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              last;

  assign last = (step_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (stat.fire) state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = stat.go ? ST_MUL1 : ST_IDLE;
      ST_MUL1: if (last) state_nxt = ST_MUL2;
      ST_MUL2: if (last) state_nxt = ST_DIV;
      ST_DIV:  if (last) state_nxt = ST_ROOT;
      ST_ROOT: if (last) state_nxt = ST_DONE;
      ST_DONE: if (stat.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // step counter, loaded with one less than the length of the next pass
  always_comb begin
    step_nxt = step_r;
    case (state_r)
      ST_UPD:  if (stat.go) step_nxt = STEP_W'(HH_W - 1);
      ST_MUL1: step_nxt = last ? STEP_W'(HH_W - 1) : step_r - 1'b1;
      ST_MUL2: step_nxt = last ? STEP_W'(Q_W - 1) : step_r - 1'b1;
      ST_DIV:  step_nxt = last ? STEP_W'(HH_W - 1) : step_r - 1'b1;
      ST_ROOT: step_nxt = last ? '0 : step_r - 1'b1;
      default: step_nxt = step_r;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.step = step_r;
    ctl.last = last;
    case (state_r)
      ST_IDLE: ctl.idle = 1'b1;
      ST_SQR:  ctl.sqr  = 1'b1;
      ST_UPD:  ctl.upd  = 1'b1;
      ST_MUL1: ctl.mul1 = 1'b1;
      ST_MUL2: ctl.mul2 = 1'b1;
      ST_DIV:  ctl.div  = 1'b1;
      ST_ROOT: ctl.root = 1'b1;
      ST_DONE: ctl.done = 1'b1;
      default: ctl.idle = 1'b0;
    endcase
  end

endmodule

// File: rtl/peak_rms_column_envelope.sv
// a non-closing sample is squared and then accumulated; the input is stalled meanwhile
// a closing sample then runs on one shared adder: two 12-step multiply passes,
// a 24-step divide and a 12-step square root, before its result is registered
// no sample is taken before the last one is through; a result register on the output
// synchronous active-low reset: settings to defaults, stream restarted, no result pending
`timescale 1ns / 1ps

module peak_rms_column_envelope #(
  parameter int MAX_COLUMNS  = prce_pkg::MAX_COLUMNS_DEF,
  parameter int SAMPLE_BITS  = prce_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_CHANNELS = prce_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [prce_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [prce_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_value,
  input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] in_sample_channel,
  input  logic                                   in_end_of_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [$clog2(MAX_COLUMNS)-1:0]         out_column_index,
  output logic [prce_pkg::OUT_W-1:0]             out_peak_height,
  output logic [prce_pkg::OUT_W-1:0]             out_rms_height,
  output logic                                   out_final_column
);

  import prce_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int POS_W  = COL_W + CNT_W;
  localparam int SQ_W   = 2 * SB + 16;
  localparam int N_W    = SQ_W + Q_W;
  localparam int SH     = 2 * (SB - 1);
  localparam int MB_W   = (SB > HH_W) ? SB : HH_W;
  localparam int PR_W   = SB + MB_W;
  localparam int BI_W   = BND_W - SPP_FRAC;
  localparam int CMP_W  = (POS_W > BI_W) ? POS_W : BI_W;
  localparam int SR_W   = HH_W + 1;

  ctrl_t ctl;
  stat_t stat;

  // configuration registers
  logic [SPP_W-1:0]  spp_r;
  logic [HH_W-1:0]   hh_r;
  logic [CH_W-1:0]   sel_r;
  logic [COLS_W-1:0] cols_r;
  logic [SPP_W-1:0]  eff_spp;

  // stream state
  logic [SB-1:0]     peak_r, peak_nxt;
  logic [SQ_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CCNT_W-1:0] col_r, col_nxt;
  logic [BND_W-1:0]  bnd_r, bnd_nxt;

  // item registers
  logic [SB-1:0]     mag_r;
  logic              hit_r;
  logic              eod_r;
  logic [2*SB-1:0]   sq_r;

  // shared-unit working registers
  logic [N_W-1:0]    acc_r;
  logic [N_W-1:0]    x_r;
  logic [Q_W-1:0]    dv_r;
  logic [CNT_W-1:0]  drem_r;
  logic [HH_W-1:0]   root_r;
  logic [SR_W-1:0]   srem_r;

  logic              out_valid_r;

  logic              fire;
  logic              in_view;
  logic [SB-1:0]     mag_in;
  logic              hit_in;
  logic [SB-1:0]     peak_upd;
  logic [SQ_W-1:0]   sum_upd;
  logic [CNT_W-1:0]  cnt_upd;
  logic [POS_W-1:0]  pos_upd;
  logic              close;
  logic              go;
  logic              out_free;
  logic              load;

  logic [CNT_W:0]    div_sh;
  logic [SR_W+1:0]   cand;
  logic [HH_W+1:0]   trial;
  logic [N_W-1:0]    alu_a, alu_b, alu_res;
  logic              alu_sub, alu_ge;

  logic [SB-1:0]     mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PR_W-1:0]   prod;

  assign fire     = in_valid && !in_stall;
  assign in_stall = ~ctl.idle;
  assign out_free = !out_valid_r || !out_stall;
  assign load     = ctl.done && out_free;

  assign eff_spp = (spp_r < SPP_MIN) ? SPP_MIN : spp_r;
  assign in_view = (32'(col_r) < 32'(cols_r)) && (32'(col_r) < 32'(MAX_COLUMNS));

  assign mag_in = in_sample_value[SB-1] ? (~$unsigned(in_sample_value) + 1'b1)
                                        : $unsigned(in_sample_value);
  assign hit_in = (in_sample_channel == sel_r) && in_view;

  assign stat = '{fire: fire, go: go, out_free: out_free};

  prce_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  prce_alu #(.W(N_W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .ge  (alu_ge)
  );

  // small multiplier: square of the sample, later peak times half height
  assign mul_a = ctl.done ? peak_r : mag_r;
  assign mul_b = ctl.done ? MB_W'(hh_r) : MB_W'(mag_r);
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r  <= SPP_RESET;
      hh_r   <= HH_RESET;
      sel_r  <= '0;
      cols_r <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SPP:  spp_r  <= cfg_data[SPP_W-1:0];
        CFG_HH:   hh_r   <= cfg_data[HH_W-1:0];
        CFG_SEL:  sel_r  <= cfg_data[CH_W-1:0];
        CFG_COLS: cols_r <= cfg_data[COLS_W-1:0];
        default:  spp_r  <= spp_r;
      endcase
    end
  end

  // accumulate step and close decision
  always_comb begin
    peak_upd = (hit_r && (mag_r > peak_r)) ? mag_r : peak_r;
    sum_upd  = hit_r ? sum_r + SQ_W'(sq_r) : sum_r;
    cnt_upd  = hit_r ? cnt_r + 1'b1 : cnt_r;
    pos_upd  = hit_r ? pos_r + 1'b1 : pos_r;
    close    = eod_r ||
               (hit_r && (CMP_W'(pos_upd) >= CMP_W'(bnd_r[BND_W-1:SPP_FRAC])));
    go       = ctl.upd && close && in_view && (cnt_upd != '0);
  end

  always_comb begin
    peak_nxt = peak_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    col_nxt  = col_r;
    bnd_nxt  = bnd_r;
    if (ctl.upd) begin
      peak_nxt = peak_upd;
      sum_nxt  = sum_upd;
      cnt_nxt  = cnt_upd;
      pos_nxt  = pos_upd;
      // end of data with nothing to emit restarts straight away
      if (!go && eod_r) begin
        peak_nxt = '0;
        sum_nxt  = '0;
        cnt_nxt  = '0;
        pos_nxt  = '0;
        col_nxt  = '0;
        bnd_nxt  = BND_W'(eff_spp);
      end
    end else if (load) begin
      peak_nxt = '0;
      sum_nxt  = '0;
      cnt_nxt  = '0;
      col_nxt  = col_r + 1'b1;
      bnd_nxt  = bnd_r + BND_W'(eff_spp);
      if (eod_r) begin
        pos_nxt = '0;
        col_nxt = '0;
        bnd_nxt = BND_W'(eff_spp);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      pos_r  <= '0;
      col_r  <= '0;
      bnd_r  <= BND_W'(SPP_RESET);
    end else begin
      peak_r <= peak_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      pos_r  <= pos_nxt;
      col_r  <= col_nxt;
      bnd_r  <= bnd_nxt;
    end
  end

  // restoring divide and root take one bit or one digit pair per cycle
  assign div_sh = {drem_r, dv_r[Q_W-1]};
  assign cand   = {srem_r, dv_r[Q_W-1:Q_W-2]};
  assign trial  = {root_r, 2'b01};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    if (ctl.mul1 || ctl.mul2) begin
      alu_a = {acc_r[N_W-2:0], 1'b0};
      alu_b = hh_r[ctl.step[HSEL_W-1:0]] ? x_r : '0;
    end else if (ctl.div) begin
      alu_a   = N_W'(div_sh);
      alu_b   = N_W'(cnt_r);
      alu_sub = 1'b1;
    end else if (ctl.root) begin
      alu_a   = N_W'(cand);
      alu_b   = N_W'(trial);
      alu_sub = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mag_r <= mag_in;
      hit_r <= hit_in;
      eod_r <= in_end_of_data;
    end
    if (ctl.sqr) sq_r <= prod[2*SB-1:0];
    if (go) begin
      acc_r <= '0;
      x_r   <= N_W'(sum_upd);
    end
    if (ctl.mul1) begin
      if (ctl.last) begin
        // sum times half height becomes the multiplicand of the second pass
        acc_r <= '0;
        x_r   <= alu_res;
      end else begin
        acc_r <= alu_res;
      end
    end
    if (ctl.mul2) begin
      if (ctl.last) begin
        dv_r   <= alu_res[SH +: Q_W];
        drem_r <= alu_res[SH+Q_W +: CNT_W];
      end else begin
        acc_r <= alu_res;
      end
    end
    if (ctl.div) begin
      drem_r <= alu_ge ? alu_res[CNT_W-1:0] : div_sh[CNT_W-1:0];
      dv_r   <= {dv_r[Q_W-2:0], alu_ge};
      if (ctl.last) begin
        root_r <= '0;
        srem_r <= '0;
      end
    end
    if (ctl.root) begin
      srem_r <= alu_ge ? alu_res[SR_W-1:0] : cand[SR_W-1:0];
      root_r <= {root_r[HH_W-2:0], alu_ge};
      dv_r   <= {dv_r[Q_W-3:0], 2'b00};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_column_index <= col_r[COL_W-1:0];
      out_peak_height  <= prod[SB-1 +: OUT_W];
      out_rms_height   <= OUT_W'(root_r);
      out_final_column <= eod_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/prce_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prce_checker #(
  parameter int MAX_COLUMNS = prce_pkg::MAX_COLUMNS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [$clog2(MAX_COLUMNS)-1:0] out_column_index,
  input logic [prce_pkg::OUT_W-1:0]     out_peak_height,
  input logic [prce_pkg::OUT_W-1:0]     out_rms_height,
  input logic                           out_final_column
);

  import prce_pkg::*;

  localparam int WORD_W = $clog2(MAX_COLUMNS) + 2 * OUT_W + 1;

  logic              heights_ok;
  logic              out_held;
  logic [WORD_W-1:0] out_word;

  assign heights_ok = (out_peak_height <= OUT_W'(HH_MAX)) &&
                      (out_rms_height <= OUT_W'(HH_MAX));
  assign out_held   = out_valid && out_stall;
  assign out_word   = {out_column_index, out_peak_height, out_rms_height, out_final_column};

  // every transfer occupies the block for at least the next cycle
  `PRCE_ASSERT_NEXT(a_transfer_busy, clk, rst_n, in_valid && !in_stall, in_stall)

  // a new result only appears at the end of a busy stretch
  `PRCE_ASSERT_IMP(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall))

  // heights never exceed the largest half height
  `PRCE_ASSERT_IMP(a_height_range, clk, rst_n, out_valid, heights_ok)

  `PRCE_ASSERT_NEXT(a_result_held, clk, rst_n, out_held, out_valid && $stable(out_word))

  // leaving reset: ready for input, nothing pending
  `PRCE_ASSERT_RESET(a_reset_clear, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind peak_rms_column_envelope prce_checker #(
  .MAX_COLUMNS (MAX_COLUMNS)
) u_prce_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_column_index (out_column_index),
  .out_peak_height  (out_peak_height),
  .out_rms_height   (out_rms_height),
  .out_final_column (out_final_column)
);
